// ===== sv/i2c_register_transaction_master_unit_defines.svh =====
`ifndef I2C_REGISTER_TRANSACTION_MASTER_UNIT_DEFINES_SVH
`define I2C_REGISTER_TRANSACTION_MASTER_UNIT_DEFINES_SVH

// checked outside reset only
`define I2C_RTM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("i2c_rtm check failed");

// checked at every edge, reset included
`define I2C_RTM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("i2c_rtm check failed");

`endif

// ===== sv/i2c_rtm_pkg.sv =====
package i2c_rtm_pkg;

  localparam int unsigned MaxBytes = 64;
  localparam int unsigned PaddrW   = 3;

  localparam logic [6:0] AddrReset  = 7'h68;
  localparam logic       ReadBit    = 1'b1;
  localparam logic       RegDevAddr = 1'b0;

  typedef enum logic [1:0] {
    OpWrite     = 2'd0,
    OpReadOfs   = 2'd1,
    OpReadCur   = 2'd2,
    OpReserved  = 2'd3
  } opcode_e;

  typedef struct packed {
    logic       sda_in;
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] reg_offset;
    logic [6:0] byte_count;
    logic       data_valid;
    logic [7:0] tx_byte;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       ready_res;
    logic       byte_request;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       nack_error;
  } out_t;

endpackage

// ===== sv/i2c_rtm_ifs.sv =====
interface i2c_rtm_in_if import i2c_rtm_pkg::*;;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2c_rtm_out_if import i2c_rtm_pkg::*;;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/i2c_register_transaction_master_unit.sv =====
// I2C register-transaction master, one bus pin-update tick per transfer. Each input
// transfer carries the sampled SDA level and, while idle, a command (write block, read
// from offset, read at current pointer); each yields exactly one result transfer with
// the SCL/SDA levels to drive for that tick plus status. A tick is accepted every clock
// cycle; its result is registered in the output register, and a new tick is taken in
// the cycle that result is read, stalling only when the output register is held.
// The 7-bit device address sits at APB byte address 0 (reset 0x68); write it only
// while no transaction runs.
`include "i2c_register_transaction_master_unit_defines.svh"

module i2c_register_transaction_master_unit import i2c_rtm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2c_rtm_in_if.sink        cmd_i,
  i2c_rtm_out_if.source     res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [4:0] {
    PhIdle, PhStartA, PhStartB, PhStartC, PhWbitLow, PhWbitHigh, PhWackLow,
    PhWackHigh, PhWackEnd, PhWaitData, PhRsetup, PhRbitHigh, PhRbitLow,
    PhMackLow, PhMackHigh, PhMackEnd, PhStopA, PhStopB, PhStopC
  } phase_e;

  typedef enum logic [1:0] {
    StAddrW, StOffset, StAddrR, StData
  } stage_e;

  phase_e     phase_q, phase_d;
  stage_e     stage_q, stage_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [6:0] bytes_left_q, bytes_left_d;
  logic [7:0] shift_q, shift_d;
  logic [1:0] mode_q, mode_d;
  logic [7:0] offset_q, offset_d;
  logic       err_q, err_d;
  logic [6:0] dev_addr_q;
  out_t       res_q, res_d;
  logic       res_vld_q;
  logic       in_acc;
  logic [6:0] cnt_sat;
  in_t        in;

  assign in      = cmd_i.data;
  assign cmd_i.ready = !res_vld_q || res_o.ready;
  assign in_acc  = cmd_i.valid && cmd_i.ready;
  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegDevAddr) ? {25'd0, dev_addr_q} : 32'd0;

  assign cnt_sat = (in.byte_count > 7'(MaxBytes)) ? 7'(MaxBytes) : in.byte_count;

  always_comb begin
    phase_d      = phase_q;
    stage_d      = stage_q;
    bit_idx_d    = bit_idx_q;
    bytes_left_d = bytes_left_q;
    shift_d      = shift_q;
    mode_d       = mode_q;
    offset_d     = offset_q;
    err_d        = err_q;
    res_d        = '0;
    res_d.scl_level = 1'b1;
    res_d.sda_level = 1'b1;
    res_d.sda_drive = 1'b1;
    case (phase_q)
      PhStartA: phase_d = PhStartB;
      PhStartB: begin
        res_d.sda_level = 1'b0;
        phase_d = PhStartC;
      end
      PhStartC: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = 1'b0;
        shift_d = {dev_addr_q, (stage_q == StAddrR) ? ReadBit : 1'b0};
        bit_idx_d = 3'd7;
        phase_d = PhWbitLow;
      end
      PhWbitLow: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = shift_q[bit_idx_q];
        phase_d = PhWbitHigh;
      end
      PhWbitHigh: begin
        res_d.sda_level = shift_q[bit_idx_q];
        if (bit_idx_q == 3'd0) begin
          phase_d = PhWackLow;
        end else begin
          bit_idx_d = bit_idx_q - 3'd1;
          phase_d = PhWbitLow;
        end
      end
      PhWackLow: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = 1'b0;
        phase_d = PhWackHigh;
      end
      PhWackHigh: begin
        res_d.sda_drive = 1'b0;
        err_d = in.sda_in;
        phase_d = PhWackEnd;
      end
      PhWackEnd: begin
        res_d.scl_level = 1'b0;
        if (err_q) begin
          res_d.done_res   = 1'b1;
          res_d.nack_error = 1'b1;
          phase_d = PhIdle;
        end else if (stage_q == StAddrW) begin
          shift_d = offset_q;
          stage_d = StOffset;
          bit_idx_d = 3'd7;
          phase_d = PhWbitLow;
        end else if (stage_q == StOffset && mode_q == OpReadOfs) begin
          stage_d = StAddrR;
          phase_d = PhStartA;
        end else if (stage_q == StAddrR) begin
          phase_d = (bytes_left_q != '0) ? PhRsetup : PhMackLow;
        end else begin
          phase_d = (bytes_left_q != '0) ? PhWaitData : PhStopA;
        end
      end
      PhWaitData: begin
        res_d.scl_level    = 1'b0;
        res_d.byte_request = 1'b1;
        if (in.data_valid) begin
          shift_d = in.tx_byte;
          bytes_left_d = bytes_left_q - 7'd1;
          stage_d = StData;
          bit_idx_d = 3'd7;
          phase_d = PhWbitLow;
        end
      end
      PhRsetup: begin
        res_d.scl_level = 1'b0;
        res_d.sda_drive = 1'b0;
        shift_d = '0;
        bit_idx_d = 3'd7;
        phase_d = PhRbitHigh;
      end
      PhRbitHigh: begin
        res_d.sda_drive = 1'b0;
        shift_d = {shift_q[6:0], in.sda_in};
        phase_d = PhRbitLow;
      end
      PhRbitLow: begin
        res_d.scl_level = 1'b0;
        res_d.sda_drive = 1'b0;
        if (bit_idx_q == 3'd0) begin
          res_d.rx_valid = 1'b1;
          res_d.rx_byte  = shift_q;
          bytes_left_d = bytes_left_q - 7'd1;
          phase_d = PhMackLow;
        end else begin
          bit_idx_d = bit_idx_q - 3'd1;
          phase_d = PhRbitHigh;
        end
      end
      PhMackLow: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = (bytes_left_q == '0);
        phase_d = PhMackHigh;
      end
      PhMackHigh: begin
        res_d.sda_level = (bytes_left_q == '0);
        phase_d = PhMackEnd;
      end
      PhMackEnd: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = (bytes_left_q == '0);
        phase_d = (bytes_left_q != '0) ? PhRsetup : PhStopA;
      end
      PhStopA: begin
        res_d.scl_level = 1'b0;
        res_d.sda_level = 1'b0;
        phase_d = PhStopB;
      end
      PhStopB: begin
        res_d.sda_level = 1'b0;
        phase_d = PhStopC;
      end
      PhStopC: begin
        res_d.done_res = 1'b1;
        phase_d = PhIdle;
      end
      default: begin
        phase_d = PhIdle;
        res_d.ready_res = 1'b1;
        if (in.cmd_valid && in.opcode != OpReserved) begin
          mode_d = in.opcode;
          offset_d = in.reg_offset;
          bytes_left_d = cnt_sat;
          err_d = 1'b0;
          bit_idx_d = 3'd0;
          shift_d = '0;
          stage_d = (in.opcode == OpReadCur) ? StAddrR : StAddrW;
          phase_d = PhStartA;
        end
      end
    endcase
    if (!res_d.sda_drive) begin
      res_d.sda_level = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      stage_q      <= StAddrW;
      bit_idx_q    <= '0;
      bytes_left_q <= '0;
      shift_q      <= '0;
      mode_q       <= '0;
      offset_q     <= '0;
      err_q        <= 1'b0;
      dev_addr_q   <= AddrReset;
      res_q        <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == RegDevAddr) begin
        dev_addr_q <= pwdata[6:0];
      end
      if (in_acc) begin
        phase_q      <= phase_d;
        stage_q      <= stage_d;
        bit_idx_q    <= bit_idx_d;
        bytes_left_q <= bytes_left_d;
        shift_q      <= shift_d;
        mode_q       <= mode_d;
        offset_q     <= offset_d;
        err_q        <= err_d;
        res_q        <= res_d;
        res_vld_q    <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q    <= 1'b0;
      end
    end
  end

  `I2C_RTM_ASSERT(a_acc_gives_result, in_acc |=> res_vld_q)
  `I2C_RTM_ASSERT(a_busy_not_ready, in_acc && phase_q != PhIdle |=> !res_q.ready_res)
  `I2C_RTM_ASSERT(a_ack_released, in_acc && phase_q == PhWackHigh |=> !res_q.sda_drive)
  `I2C_RTM_ASSERT_ALWAYS(a_count_bound, bytes_left_q <= 7'(MaxBytes))

endmodule
